@@ design/modular_exponentiation_macros.svh @@
// Assertion macros shared by the modular exponentiation modules.
// No dependencies; included by the files that carry concurrent checks.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MEXP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled during reset.
`define MEXP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

@@ design/mexp_pkg.sv @@
// Shared constants and types for the modular exponentiation core.
// No dependencies; imported by every module of the block.
package mexp_pkg;

  localparam int WORD_BITS_DEFAULT = 32;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 1'b1;

  // Status of one serial modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

@@ design/mexp_mulmod.sv @@
// Bit-serial interleaved modular multiplier: one bit of the multiplier per cycle.
// Depends on mexp_pkg and modular_exponentiation_macros.svh.
`include "modular_exponentiation_macros.svh"

module mexp_mulmod #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [WORD_BITS-1:0]   a,
  input  logic [WORD_BITS-1:0]   b,
  input  logic [WORD_BITS-1:0]   m,
  output mexp_pkg::mm_stat_t     stat,
  output logic [WORD_BITS-1:0]   r
);
  import mexp_pkg::*;

  localparam int CW = $clog2(WORD_BITS + 1);

  logic             busy;
  logic             done;
  logic [CW-1:0]    cnt;
  logic [WORD_BITS-1:0] a_reg;
  logic [WORD_BITS-1:0] bsh;
  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS:0]   dbl_red;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   m_ext;
  logic [WORD_BITS-1:0] r_next;

  // Each step doubles the partial remainder and adds a when the current
  // multiplier bit is set, reducing after the doubling and again after the addition.
  always_comb begin
    m_ext   = {1'b0, m};
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = {1'b0, dbl_red[WORD_BITS-1:0]} +
              (bsh[WORD_BITS-1] ? {1'b0, a_reg} : '0);
    r_next  = (sum >= m_ext) ? WORD_BITS'(sum - m_ext) : sum[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(WORD_BITS);
        a_reg <= a;
        bsh   <= b;
        r     <= '0;
      end else if (busy) begin
        r   <= r_next;
        bsh <= {bsh[WORD_BITS-2:0], 1'b0};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  `MEXP_ASSERT_IMP(a_start_idle, clk, rst, start, !busy)
  `MEXP_ASSERT_IMP(a_result_reduced, clk, rst, done && (m != '0), r < m)
  `MEXP_ASSERT_NXT(a_done_frees, clk, rst, done, !busy)

endmodule

@@ design/modular_exponentiation.sv @@
// Right-to-left square-and-multiply modular exponentiation, one base per transaction.
// A new base is accepted only in the idle state, after the previous result has been loaded into
// the output register; that load waits while an earlier result is held with out_ready low.
// The base is first reduced, then each exponent bit is processed on two bit-serial
// modular multipliers. A zero exponent or zero modulus skips the multipliers and goes
// straight to the finish state. Reset sets modulus 1, exponent 0, no output.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
  parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]                cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [WORD_BITS-1:0]                base_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [WORD_BITS-1:0]                power_result
);
  import mexp_pkg::*;

  localparam int SW = $clog2(WORD_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_FINISH
  } state_t;

  state_t               state;
  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] exponent;
  logic [WORD_BITS-1:0] e_sh;
  logic [WORD_BITS-1:0] b_cur;
  logic [WORD_BITS-1:0] acc;
  logic [SW-1:0]        step_cnt;

  logic                 accept;
  logic                 sq_start;
  logic [WORD_BITS-1:0] sq_a;
  logic [WORD_BITS-1:0] sq_b;
  logic [WORD_BITS-1:0] sq_r;
  mm_stat_t             sq_stat;
  logic                 mul_start;
  logic [WORD_BITS-1:0] mul_r;
  mm_stat_t             mul_stat;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= WORD_BITS'(1);
      exponent <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:  modulus  <= cfg_data;
        REG_EXPONENT: exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // The squaring unit also reduces the incoming base, as 1 times base mod m.
  always_comb begin
    sq_start  = 1'b0;
    sq_a      = b_cur;
    sq_b      = b_cur;
    mul_start = 1'b0;
    case (state)
      ST_IDLE: begin
        sq_start = accept && (exponent != '0) && (modulus != '0);
        sq_a     = WORD_BITS'(1);
        sq_b     = base_value;
      end
      ST_STEP_GO: begin
        sq_start  = 1'b1;
        mul_start = e_sh[0];
      end
      default: ;
    endcase
  end

  mexp_mulmod #(.WORD_BITS(WORD_BITS)) u_square (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .a     (sq_a),
    .b     (sq_b),
    .m     (modulus),
    .stat  (sq_stat),
    .r     (sq_r)
  );

  mexp_mulmod #(.WORD_BITS(WORD_BITS)) u_multiply (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (acc),
    .b     (b_cur),
    .m     (modulus),
    .stat  (mul_stat),
    .r     (mul_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step_cnt  <= '0;
    end else begin
      // In the finish state the output register is handled below.
      if (out_valid && out_ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (exponent == '0) begin
              acc   <= WORD_BITS'(1);
              state <= ST_FINISH;
            end else if (modulus == '0) begin
              acc   <= '0;
              state <= ST_FINISH;
            end else begin
              acc   <= (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
              e_sh  <= exponent;
              state <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (sq_stat.done) begin
            b_cur    <= sq_r;
            step_cnt <= SW'(WORD_BITS);
            state    <= ST_STEP_GO;
          end
        end
        ST_STEP_GO: begin
          state <= ST_STEP_WAIT;
        end
        ST_STEP_WAIT: begin
          if (sq_stat.done) begin
            b_cur    <= sq_r;
            if (e_sh[0]) begin
              acc <= mul_r;
            end
            e_sh     <= {1'b0, e_sh[WORD_BITS-1:1]};
            step_cnt <= step_cnt - SW'(1);
            state    <= (step_cnt == SW'(1)) ? ST_FINISH : ST_STEP_GO;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            power_result <= acc;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MEXP_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)
  `MEXP_ASSERT_IMP(a_units_lockstep, clk, rst, mul_stat.done, sq_stat.done)
  `MEXP_ASSERT_IMP(a_done_expected, clk, rst, sq_stat.done, (state == ST_REDUCE) || (state == ST_STEP_WAIT))

endmodule
